[src/bfknn_pkg.sv]
// Shared types and constants for the brute-force 3D k-nearest-neighbor search block.
package bfknn_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_POINTS_DEF    = 1024;
    localparam int MAX_NEIGHBORS_DEF = 16;
    localparam int COORD_BITS_DEF    = 16;

    // Fixed field widths of the request and result ports.
    localparam int SLOT_W = 10;
    localparam int DIST_W = 34;
    localparam int RANK_W = 4;
    localparam int PC_W   = 11;
    localparam int NC_W   = 5;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Saturation value of a squared distance.
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Register reset values.
    localparam logic [PC_W-1:0] PC_RESET = 11'd1024;
    localparam logic [NC_W-1:0] NC_RESET = 5'd1;

    // Request action codes.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Register index codes, taken from address bit 2.
    localparam logic REG_POINT_COUNT    = 1'b0;
    localparam logic REG_NEIGHBOR_COUNT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_we;
        logic query_init;
        logic rd_en;
        logic emit;
        logic emit_last;
    } bfknn_cmd_t;

endpackage

[src/bfknn_ctrl.sv]
// Controller state machine: request intake, point scan, pipeline drain and result emission.
module bfknn_ctrl
    import bfknn_pkg::*;
#(
    parameter int MAX_POINTS    = MAX_POINTS_DEF,
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int NW = $clog2(MAX_POINTS + 1),
    localparam int KW = $clog2(MAX_NEIGHBORS + 1),
    localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             action,
    input  logic [PC_W-1:0]  point_count,
    input  logic [NC_W-1:0]  neighbor_count,
    input  logic             pipe_idle,
    output logic             busy,
    output bfknn_cmd_t       cmd,
    output logic [AW-1:0]    rd_addr,
    output logic [KW-1:0]    k_eff,
    output logic [IW-1:0]    emit_idx
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t         state_reg;
    logic [AW-1:0]  scan_addr_reg;
    logic [NW-1:0]  n_eff_reg;
    logic [KW-1:0]  k_eff_reg;
    logic [IW-1:0]  emit_idx_reg;

    logic           take;
    logic [31:0]    n_wide;
    logic [31:0]    k_wide;
    logic [NW-1:0]  n_eff_next;
    logic [KW-1:0]  k_eff_next;
    logic           scan_last;
    logic           emit_last;

    // Effective counts: saturate at the store and list sizes, k never above n.
    always_comb
    begin
        n_wide = (32'(point_count) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : 32'(point_count);
        k_wide = (32'(neighbor_count) > 32'(MAX_NEIGHBORS)) ? 32'(MAX_NEIGHBORS)
                                                             : 32'(neighbor_count);
        if (k_wide > n_wide)
        begin
            k_wide = n_wide;
        end
        n_eff_next = n_wide[NW-1:0];
        k_eff_next = k_wide[KW-1:0];
    end

    assign busy      = (state_reg != ST_IDLE);
    assign take      = start && !busy;
    assign scan_last = (NW'(scan_addr_reg) == (n_eff_reg - NW'(1)));
    assign emit_last = (KW'(emit_idx_reg) == (k_eff_reg - KW'(1)));

    // Commands decoded from the current state and from the request taken while idle.
    always_comb
    begin
        cmd.load_we    = take && (action == ACT_LOAD);
        cmd.query_init = take && (action == ACT_QUERY);
        cmd.rd_en      = (state_reg == ST_SCAN);
        cmd.emit       = (state_reg == ST_EMIT);
        cmd.emit_last  = (state_reg == ST_EMIT) && emit_last;
    end

    assign rd_addr  = scan_addr_reg;
    assign k_eff    = k_eff_reg;
    assign emit_idx = emit_idx_reg;

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_addr_reg <= '0;
            n_eff_reg     <= '0;
            k_eff_reg     <= '0;
            emit_idx_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take && (action == ACT_QUERY))
                    begin
                        n_eff_reg     <= n_eff_next;
                        k_eff_reg     <= k_eff_next;
                        scan_addr_reg <= '0;
                        emit_idx_reg  <= '0;
                        if (k_eff_next != '0)
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    scan_addr_reg <= scan_addr_reg + AW'(1);
                    if (scan_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (pipe_idle)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    emit_idx_reg <= emit_idx_reg + IW'(1);
                    if (emit_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A scan read never goes past the searched points.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (NW'(scan_addr_reg) < n_eff_reg))
        else $error("scan address beyond point count");

    // A query that reaches the scan has at least one neighbor to return.
    a_scan_has_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (k_eff_reg != '0) && (KW'(emit_idx_reg) == '0))
        else $error("scan started without neighbors to report");

    // Emission never reads past the neighbors of the current query.
    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (KW'(emit_idx_reg) < k_eff_reg))
        else $error("emit index beyond neighbor count");

endmodule

[src/bfknn_dp.sv]
// Datapath: point store, distance pipeline, sorted best list and result registers.
module bfknn_dp
    import bfknn_pkg::*;
#(
    parameter int MAX_POINTS    = MAX_POINTS_DEF,
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int KW = $clog2(MAX_NEIGHBORS + 1),
    localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bfknn_cmd_t                   cmd,
    input  logic [AW-1:0]                rd_addr,
    input  logic [KW-1:0]                k_eff,
    input  logic [IW-1:0]                emit_idx,
    input  logic [SLOT_W-1:0]            point_slot,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    output logic                         pipe_idle,
    output logic                         result_valid,
    output logic [SLOT_W-1:0]            neighbor_index,
    output logic [DIST_W-1:0]            squared_distance,
    output logic [RANK_W-1:0]            rank,
    output logic                         last
);

    localparam int CB   = COORD_BITS;
    localparam int SQW  = 2 * CB;
    localparam int SUMW = 2 * CB + 2;
    localparam int CW   = (SUMW > DIST_W) ? SUMW : DIST_W;

    // Point store: x, y and z packed into one word per slot.
    logic [3*CB-1:0] point_mem [MAX_POINTS];

    logic signed [CB-1:0] qx_reg, qy_reg, qz_reg;
    logic [3*CB-1:0]      rd_data_reg;
    logic                 vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic [AW-1:0]        idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [CB-1:0]        ax_reg, ay_reg, az_reg;
    logic [SQW-1:0]       sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_W-1:0]    dist4_reg;

    logic [DIST_W-1:0]    best_dist_reg [MAX_NEIGHBORS];
    logic [AW-1:0]        best_slot_reg [MAX_NEIGHBORS];
    logic                 best_vld_reg  [MAX_NEIGHBORS];

    logic                 result_valid_reg;
    logic [SLOT_W-1:0]    neighbor_index_reg;
    logic [DIST_W-1:0]    squared_distance_reg;
    logic [RANK_W-1:0]    rank_reg;
    logic                 last_reg;

    logic [31:0]          slot_wide;
    logic                 slot_ok;
    logic [AW-1:0]        wr_addr;
    logic signed [CB-1:0] px, py, pz;
    logic [CB-1:0]        ax_next, ay_next, az_next;
    logic [SUMW-1:0]      sum;
    logic [CW-1:0]        sum_ext;
    logic [DIST_W-1:0]    dist_next;
    logic                 gt      [MAX_NEIGHBORS];
    logic                 gt_prev [MAX_NEIGHBORS];
    logic                 active  [MAX_NEIGHBORS];
    logic                 ins     [MAX_NEIGHBORS];
    logic [31:0]          out_slot_wide;
    logic [31:0]          rank_wide;

    // Absolute coordinate difference, exact in CB bits.
    function automatic logic [CB-1:0] abs_diff(input logic signed [CB-1:0] a,
                                               input logic signed [CB-1:0] b);
        logic signed [CB:0] d;
        d = (CB+1)'(a) - (CB+1)'(b);
        if (d < 0)
        begin
            d = -d;
        end
        return d[CB-1:0];
    endfunction

    // Load address: slots beyond the store are dropped.
    assign slot_wide = 32'(point_slot);
    assign slot_ok   = (slot_wide < 32'(MAX_POINTS));
    assign wr_addr   = slot_wide[AW-1:0];

    // Point store write on load, registered read during the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.load_we && slot_ok)
        begin
            point_mem[wr_addr] <= {coord_x, coord_y, coord_z};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= point_mem[rd_addr];
        end
    end

    // Query point capture.
    always_ff @(posedge clk)
    begin
        if (cmd.query_init)
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
            qz_reg <= coord_z;
        end
    end

    // Stage valid flags of the distance pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= cmd.rd_en;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    assign pipe_idle = !(vld1_reg || vld2_reg || vld3_reg || vld4_reg);

    // Differences, squares and the saturated sum.
    always_comb
    begin
        px      = rd_data_reg[3*CB-1:2*CB];
        py      = rd_data_reg[2*CB-1:CB];
        pz      = rd_data_reg[CB-1:0];
        ax_next = abs_diff(qx_reg, px);
        ay_next = abs_diff(qy_reg, py);
        az_next = abs_diff(qz_reg, pz);
        sum     = SUMW'(sqx_reg) + SUMW'(sqy_reg) + SUMW'(sqz_reg);
        sum_ext = CW'(sum);
        if (sum_ext > CW'(DIST_MAX))
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = sum_ext[DIST_W-1:0];
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        idx1_reg  <= rd_addr;
        idx2_reg  <= idx1_reg;
        idx3_reg  <= idx2_reg;
        idx4_reg  <= idx3_reg;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        az_reg    <= az_next;
        sqx_reg   <= ax_reg * ax_reg;
        sqy_reg   <= ay_reg * ay_reg;
        sqz_reg   <= az_reg * az_reg;
        dist4_reg <= dist_next;
    end

    // Per-entry insertion compare: entries farther than the new point move down.
    // The new point lands in the first entry that is empty or farther, so it sits
    // right behind the last entry at a distance not above its own.
    always_comb
    begin
        for (int j = 0; j < MAX_NEIGHBORS; j++)
        begin
            gt[j]      = best_vld_reg[j] && (best_dist_reg[j] > dist4_reg);
            active[j]  = (32'(j) < 32'(k_eff));
            gt_prev[j] = 1'b0;
            ins[j]     = active[j] && (gt[j] || !best_vld_reg[j]);
        end
        for (int j = 1; j < MAX_NEIGHBORS; j++)
        begin
            gt_prev[j] = gt[j-1];
            ins[j]     = ins[j] && best_vld_reg[j-1] && !gt[j-1];
        end
    end

    // Best list valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                best_vld_reg[j] <= 1'b0;
            end
        end
        else if (cmd.query_init)
        begin
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                best_vld_reg[j] <= 1'b0;
            end
        end
        else if (vld4_reg)
        begin
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                if (active[j] && (gt_prev[j] || ins[j]))
                begin
                    best_vld_reg[j] <= 1'b1;
                end
            end
        end
    end

    // Best list payload: shift down behind the insertion point, new entry at it.
    always_ff @(posedge clk)
    begin
        if (vld4_reg)
        begin
            for (int j = 1; j < MAX_NEIGHBORS; j++)
            begin
                if (active[j] && gt_prev[j])
                begin
                    best_dist_reg[j] <= best_dist_reg[j-1];
                    best_slot_reg[j] <= best_slot_reg[j-1];
                end
            end
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                if (ins[j])
                begin
                    best_dist_reg[j] <= dist4_reg;
                    best_slot_reg[j] <= idx4_reg;
                end
            end
        end
    end

    // Result registers.
    assign out_slot_wide = 32'(best_slot_reg[emit_idx]);
    assign rank_wide     = 32'(emit_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        neighbor_index_reg   <= out_slot_wide[SLOT_W-1:0];
        squared_distance_reg <= best_dist_reg[emit_idx];
        rank_reg             <= rank_wide[RANK_W-1:0];
        last_reg             <= cmd.emit_last;
    end

    assign result_valid     = result_valid_reg;
    assign neighbor_index   = neighbor_index_reg;
    assign squared_distance = squared_distance_reg;
    assign rank             = rank_reg;
    assign last             = last_reg;

    // Every emitted entry holds a found neighbor.
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> best_vld_reg[emit_idx])
        else $error("emitting an empty list entry");

    // A new query never starts with distances still in flight.
    a_init_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.query_init |-> pipe_idle && !cmd.rd_en)
        else $error("query started while the pipeline is busy");

    // The list stays packed and sorted by ascending distance.
    for (genvar g = 1; g < MAX_NEIGHBORS; g++)
    begin : g_sorted
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            best_vld_reg[g] |-> best_vld_reg[g-1] && (best_dist_reg[g-1] <= best_dist_reg[g]))
            else $error("best list out of order");
    end

endmodule

[src/brute_force_knn_search_3d.sv]
// Top level of the brute-force 3D k-nearest-neighbor search: configuration registers and wiring.
//
// A load request (action 0) writes one point into the store; busy stays low. A query request
// (action 1) holds busy while it searches, with point_count and neighbor_count saturated at
// MAX_POINTS and MAX_NEIGHBORS and neighbor_count capped at point_count: one point is read
// from the single-port point store each cycle, then a four-stage distance pipeline drains,
// then one result leaves per cycle from the sorted list. Results come on result_valid,
// sorted by distance, ties to the lower slot, the final one flagged by last; the receiver
// cannot stall them and must take each in its cycle. A query with a zero effective count
// returns nothing and keeps busy low. Reading a slot never loaded returns an undefined
// point. Configuration must be written over the APB port only while busy is low and no
// result is pending; the block itself does not enforce it.
module brute_force_knn_search_3d
    import bfknn_pkg::*;
#(
    parameter int MAX_POINTS    = MAX_POINTS_DEF,
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic [SLOT_W-1:0]            point_slot,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    output logic                         result_valid,
    output logic [SLOT_W-1:0]            neighbor_index,
    output logic [DIST_W-1:0]            squared_distance,
    output logic [RANK_W-1:0]            rank,
    output logic                         last
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int KW = $clog2(MAX_NEIGHBORS + 1);
    localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    logic [PC_W-1:0] point_count_reg;
    logic [NC_W-1:0] neighbor_count_reg;

    bfknn_cmd_t      cmd;
    logic [AW-1:0]   rd_addr;
    logic [KW-1:0]   k_eff;
    logic [IW-1:0]   emit_idx;
    logic            pipe_idle;

    // Configuration registers, selected by address bit 2.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg    <= PC_RESET;
            neighbor_count_reg <= NC_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_POINT_COUNT:    point_count_reg    <= pwdata[PC_W-1:0];
                REG_NEIGHBOR_COUNT: neighbor_count_reg <= pwdata[NC_W-1:0];
                default:            point_count_reg    <= point_count_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr[2])
            REG_POINT_COUNT:    prdata = APB_DATA_W'(point_count_reg);
            REG_NEIGHBOR_COUNT: prdata = APB_DATA_W'(neighbor_count_reg);
            default:            prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    bfknn_ctrl #(
        .MAX_POINTS    (MAX_POINTS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .action         (action),
        .point_count    (point_count_reg),
        .neighbor_count (neighbor_count_reg),
        .pipe_idle      (pipe_idle),
        .busy           (busy),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .k_eff          (k_eff),
        .emit_idx       (emit_idx)
    );

    bfknn_dp #(
        .MAX_POINTS    (MAX_POINTS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .COORD_BITS    (COORD_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .rd_addr          (rd_addr),
        .k_eff            (k_eff),
        .emit_idx         (emit_idx),
        .point_slot       (point_slot),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .coord_z          (coord_z),
        .pipe_idle        (pipe_idle),
        .result_valid     (result_valid),
        .neighbor_index   (neighbor_index),
        .squared_distance (squared_distance),
        .rank             (rank),
        .last             (last)
    );

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the brute-force 3D k-nearest-neighbor search block.
module testbench
    import bfknn_pkg::*;
;

    localparam int CW = COORD_BITS_DEF;
    localparam logic signed [CW-1:0] COORD_MAX = 16'sh7FFF;
    localparam logic signed [CW-1:0] COORD_MIN = 16'sh8000;
    localparam logic [APB_ADDR_W-1:0] ADDR_POINT_COUNT    = {REG_POINT_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_NEIGHBOR_COUNT = {REG_NEIGHBOR_COUNT, 2'b00};

    // One request toward the block: a point load or a neighbor query.
    typedef struct {
        logic                   action;
        logic [SLOT_W-1:0]      slot;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic signed [CW-1:0]   z;
    } knn_request_t;

    // One neighbor result as it should appear on the result ports.
    typedef struct {
        logic [SLOT_W-1:0]      index;
        logic [DIST_W-1:0]      sq_dist;
        logic [RANK_W-1:0]      rank;
        logic                   last;
    } neighbor_t;

    // Clock, reset and block ports.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   action = ACT_LOAD;
    logic [SLOT_W-1:0]      point_slot = '0;
    logic signed [CW-1:0]   coord_x = '0;
    logic signed [CW-1:0]   coord_y = '0;
    logic signed [CW-1:0]   coord_z = '0;
    logic                   result_valid;
    logic [SLOT_W-1:0]      neighbor_index;
    logic [DIST_W-1:0]      squared_distance;
    logic [RANK_W-1:0]      rank;
    logic                   last;

    // Shadow copy of the point store and of the registers.
    logic signed [CW-1:0]   cloud_x [MAX_POINTS_DEF];
    logic signed [CW-1:0]   cloud_y [MAX_POINTS_DEF];
    logic signed [CW-1:0]   cloud_z [MAX_POINTS_DEF];
    logic                   loaded [MAX_POINTS_DEF];
    logic [PC_W-1:0]        cfg_point_count = PC_RESET;
    logic [NC_W-1:0]        cfg_neighbor_count = NC_RESET;

    knn_request_t           pending_requests [$];
    neighbor_t              expected_neighbors [$];
    knn_request_t           offered;
    neighbor_t              want;

    int unsigned            pushed_count = 0;
    int unsigned            accepted_count = 0;
    int unsigned            loads_done = 0;
    int unsigned            queries_done = 0;
    int unsigned            results_checked = 0;
    int unsigned            config_writes = 0;
    int unsigned            mismatch_count = 0;
    int unsigned            gap_left = 0;
    int unsigned            gap_pct = 20;
    int unsigned            coord_spread = 1;

    brute_force_knn_search_3d dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .point_slot       (point_slot),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .coord_z          (coord_z),
        .result_valid     (result_valid),
        .neighbor_index   (neighbor_index),
        .squared_distance (squared_distance),
        .rank             (rank),
        .last             (last)
    );

    always #5 clk = ~clk;

    // Report the first few mismatches in full and count the rest.
    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    // Work out the sorted nearest neighbors of a query and queue them as expected results.
    task automatic predict_neighbors(input logic signed [CW-1:0] qx,
                                     input logic signed [CW-1:0] qy,
                                     input logic signed [CW-1:0] qz);
        int unsigned        n;
        int unsigned        k;
        int unsigned        filled;
        int unsigned        i;
        int unsigned        j;
        longint             dx;
        longint             dy;
        longint             dz;
        longint             sum;
        logic [DIST_W-1:0]  d;
        logic [DIST_W-1:0]  best_d [MAX_NEIGHBORS_DEF];
        logic [SLOT_W-1:0]  best_i [MAX_NEIGHBORS_DEF];
        neighbor_t          nb;
        n = (cfg_point_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : cfg_point_count;
        k = (cfg_neighbor_count > MAX_NEIGHBORS_DEF) ? MAX_NEIGHBORS_DEF : cfg_neighbor_count;
        if (k > n)
            k = n;
        filled = 0;
        if (k == 0)
            return;
        for (i = 0; i < n; i++)
        begin
            dx = longint'(qx) - longint'(cloud_x[i]);
            dy = longint'(qy) - longint'(cloud_y[i]);
            dz = longint'(qz) - longint'(cloud_z[i]);
            sum = dx * dx + dy * dy + dz * dz;
            d = (sum > longint'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
            if (filled == k && d >= best_d[k-1])
                continue;
            // Insert behind every entry at the same distance so lower slots stay first.
            j = (filled < k) ? filled : k - 1;
            while (j > 0 && best_d[j-1] > d)
            begin
                best_d[j] = best_d[j-1];
                best_i[j] = best_i[j-1];
                j--;
            end
            best_d[j] = d;
            best_i[j] = SLOT_W'(i);
            if (filled < k)
                filled++;
        end
        for (j = 0; j < filled; j++)
        begin
            nb.index   = best_i[j];
            nb.sq_dist = best_d[j];
            nb.rank    = RANK_W'(j);
            nb.last    = (j + 1 == filled);
            expected_neighbors.push_back(nb);
        end
    endtask

    // Request driver: offers queued requests, holds them while busy, inserts idle bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (offered.action == ACT_LOAD)
                begin
                    cloud_x[offered.slot] = offered.x;
                    cloud_y[offered.slot] = offered.y;
                    cloud_z[offered.slot] = offered.z;
                    loads_done++;
                end
                else
                begin
                    predict_neighbors(offered.x, offered.y, offered.z);
                    queries_done++;
                end
                accepted_count++;
                if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
                    gap_left = $urandom_range(1, 10);
            end
            if (!start || !busy)
            begin
                if (gap_left != 0)
                begin
                    start <= 1'b0;
                    gap_left--;
                end
                else if (pending_requests.size() != 0)
                begin
                    offered = pending_requests.pop_front();
                    start      <= 1'b1;
                    action     <= offered.action;
                    point_slot <= offered.slot;
                    coord_x    <= offered.x;
                    coord_y    <= offered.y;
                    coord_z    <= offered.z;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Result monitor: every strobed result must match the oldest expected neighbor.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_neighbors.size() == 0)
                flag_mismatch($sformatf("unexpected result index %0d distance %0d rank %0d",
                                        neighbor_index, squared_distance, rank));
            else
            begin
                want = expected_neighbors.pop_front();
                results_checked++;
                if (neighbor_index !== want.index || squared_distance !== want.sq_dist ||
                    rank !== want.rank || last !== want.last)
                    flag_mismatch($sformatf(
                        "expected index %0d dist %0d rank %0d last %0b, got %0d %0d %0d %0b",
                        want.index, want.sq_dist, want.rank, want.last,
                        neighbor_index, squared_distance, rank, last));
            end
        end
    end

    // Random coordinate: a tight cluster that forces ties, or the full range with extremes.
    function automatic logic signed [CW-1:0] rand_coord(input int unsigned spread);
        int t;
        if (spread == 0)
        begin
            t = $urandom_range(0, 6) - 3;
            return t[CW-1:0];
        end
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            default: return CW'($urandom());
        endcase
    endfunction

    function automatic void push_load(input int unsigned slot, input logic signed [CW-1:0] x,
                                      input logic signed [CW-1:0] y,
                                      input logic signed [CW-1:0] z);
        knn_request_t req;
        req.action = ACT_LOAD;
        req.slot   = SLOT_W'(slot);
        req.x      = x;
        req.y      = y;
        req.z      = z;
        pending_requests.push_back(req);
        loaded[slot] = 1'b1;
        pushed_count++;
    endfunction

    // A query is preceded by loads of every searched slot not yet written.
    function automatic void push_query(input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y,
                                       input logic signed [CW-1:0] z);
        int unsigned  n;
        int unsigned  s;
        knn_request_t req;
        n = (cfg_point_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : cfg_point_count;
        for (s = 0; s < n; s++)
            if (!loaded[s])
                push_load(s, rand_coord(coord_spread), rand_coord(coord_spread),
                          rand_coord(coord_spread));
        req.action = ACT_QUERY;
        req.slot   = SLOT_W'($urandom());
        req.x      = x;
        req.y      = y;
        req.z      = z;
        pending_requests.push_back(req);
        pushed_count++;
    endfunction

    // Wait until every request is taken and every result has come, then let the block settle.
    task automatic wait_idle();
        int unsigned spent;
        spent = 0;
        while ((accepted_count != pushed_count || expected_neighbors.size() != 0 ||
                busy !== 1'b0) && spent < 50000)
        begin
            @(negedge clk);
            spent++;
        end
        repeat (12) @(negedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write both registers while the block is idle and read them back.
    task automatic set_config(input int unsigned pc, input int unsigned nc);
        logic [APB_DATA_W-1:0] rd;
        wait_idle();
        apb_write(ADDR_POINT_COUNT, pc);
        cfg_point_count = pc[PC_W-1:0];
        apb_write(ADDR_NEIGHBOR_COUNT, nc);
        cfg_neighbor_count = nc[NC_W-1:0];
        config_writes += 2;
        apb_read(ADDR_POINT_COUNT, rd);
        if (rd[PC_W-1:0] !== cfg_point_count)
            flag_mismatch($sformatf("point_count reads %0d, expected %0d",
                                    rd[PC_W-1:0], cfg_point_count));
        apb_read(ADDR_NEIGHBOR_COUNT, rd);
        if (rd[NC_W-1:0] !== cfg_neighbor_count)
            flag_mismatch($sformatf("neighbor_count reads %0d, expected %0d",
                                    rd[NC_W-1:0], cfg_neighbor_count));
    endtask

    // Stimulus: directed corners, random phases over many settings, then back-to-back queries.
    initial
    begin
        int unsigned ph;
        int unsigned it;
        int unsigned pc;
        int unsigned nc;
        int unsigned lim;
        for (int s = 0; s < MAX_POINTS_DEF; s++)
            loaded[s] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Extreme coordinates give the largest distance; the top slot is loaded too.
        set_config(2, 2);
        push_load(0, COORD_MAX, COORD_MAX, COORD_MAX);
        push_load(1, COORD_MIN, COORD_MIN, COORD_MIN);
        push_load(MAX_POINTS_DEF - 1, 0, 0, 0);
        push_query(COORD_MIN, COORD_MIN, COORD_MIN);
        push_query(COORD_MAX, COORD_MAX, COORD_MAX);
        push_query(0, 0, 0);
        push_query(-1, -1, -1);

        // Duplicate points and equal distances resolve to the lower slot first.
        set_config(4, 16);
        push_load(0, 5, 5, 5);
        push_load(1, 5, 5, 5);
        push_load(2, 100, 0, 0);
        push_load(3, -100, 0, 0);
        push_query(0, 0, 0);

        // Zero point count, zero neighbor count, neighbor count above the maximum.
        set_config(0, 31);
        push_query(1, 2, 3);
        set_config(4, 0);
        push_query(0, 0, 0);
        set_config(4, 31);
        push_query(7, -7, 7);
        set_config(1, 1);
        push_query(COORD_MIN, COORD_MAX, 0);

        // Random phases, each with its own settings, coordinate spread and idle rate.
        for (ph = 0; ph < 12; ph++)
        begin
            case ($urandom_range(0, 9))
                0: pc = 0;
                1: pc = $urandom_range(41, 160);
                default: pc = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 9))
                0: nc = 0;
                1: nc = $urandom_range(17, 31);
                default: nc = $urandom_range(1, 16);
            endcase
            set_config(pc, nc);
            gap_pct = $urandom_range(0, 3) * 10;
            coord_spread = $urandom_range(0, 2);
            lim = (pc + 4 > MAX_POINTS_DEF - 1) ? MAX_POINTS_DEF - 1 : pc + 4;
            for (it = 0; it < 22; it++)
            begin
                if ($urandom_range(0, 1))
                    push_query(rand_coord(coord_spread), rand_coord(coord_spread),
                               rand_coord(coord_spread));
                else
                    push_load(($urandom_range(0, 9) < 7) ? $urandom_range(0, lim)
                                                         : $urandom_range(0, 1023),
                              rand_coord(coord_spread), rand_coord(coord_spread),
                              rand_coord(coord_spread));
            end
        end

        // Final stretch without idling: several neighbor counts over a mid-sized point set and a single point.
        wait_idle();
        gap_pct = 0;
        coord_spread = 1;
        set_config(48, 16);
        push_query(rand_coord(1), rand_coord(1), rand_coord(1));
        push_query(COORD_MIN, COORD_MAX, COORD_MIN);
        set_config(48, 31);
        push_query(rand_coord(1), rand_coord(1), rand_coord(1));
        set_config(48, 1);
        push_query(rand_coord(1), rand_coord(1), rand_coord(1));
        set_config(1, 16);
        push_query(rand_coord(1), rand_coord(1), rand_coord(1));
        push_query(COORD_MAX, COORD_MIN, COORD_MAX);

        wait_idle();
        if (expected_neighbors.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    expected_neighbors.size()));
        $display("Run covered %0d point loads and %0d queries; %0d neighbor results checked.",
                 loads_done, queries_done, results_checked);
        $display("Register writes: %0d; mismatches: %0d.", config_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog for a hung block.
    initial
    begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

[brute_force_knn_search_3d.f]
src/bfknn_pkg.sv
src/bfknn_ctrl.sv
src/bfknn_dp.sv
src/brute_force_knn_search_3d.sv
dv/testbench.sv
